### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the pass cost window statistics block.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/pcws_pkg.sv
// Package for the pass cost window statistics block: widths, limits and defaults.
// Depends on nothing.
`timescale 1ns / 1ps
package pcws_pkg;
    localparam int HISTORY_DEPTH_DEF = 60;
    localparam int TYPE_COUNT_DEF    = 5;
    localparam int TIME_W  = 24;
    localparam int DRAW_W  = 20;
    localparam int CNT_W   = 32;
    localparam int FNUM_W  = 64;
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_CLOSE  = 1'b1;
endpackage

### hdl/pass_cost_window_stats_top.sv
// Top level of the pass cost window statistics block.
// Depends on pcws_pkg and assert_macros.svh.
//
//  channel | direction | handshake       | payload
//  in      | into      | in_valid/stall  | req_type .. budget_exceeded
//  out     | out of    | out_valid/stall | last_of_run .. frames_total
//
// A pass record is accepted and then added to its type's accumulator; one whose pass
// type is out of range is dropped. A frame close is accepted and then commits each type
// in turn, writing one ring entry for a type that saw a record in a taken frame. Each
// type is then scanned over its stored samples and its mean is found in the shared
// restoring divider; a type with an empty ring skips the scan and the divider.
// Reset clears all control state and accumulators; history needs no clearing pass.
// Results wait in an output register while out_stall is high; no request is
// taken until the close has delivered all its results.
`timescale 1ns / 1ps
module pass_cost_window_stats_top #(
    parameter int HISTORY_DEPTH = pcws_pkg::HISTORY_DEPTH_DEF,
    parameter int TYPE_COUNT    = pcws_pkg::TYPE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  pass_kind,
    input  logic [19:0] pass_time,
    input  logic [15:0] pass_draws,
    input  logic [63:0] frame_number,
    input  logic        budget_exceeded,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        last_of_run,
    output logic [3:0]  type_index,
    output logic [5:0]  sample_count,
    output logic        present_now,
    output logic [23:0] latest_time,
    output logic [19:0] latest_draws,
    output logic [23:0] mean_time,
    output logic [23:0] max_time,
    output logic [19:0] max_draws,
    output logic        frame_taken,
    output logic [31:0] overrun_total,
    output logic [31:0] frames_total
);
    import pcws_pkg::*;
    `include "assert_macros.svh"

    localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW   = $clog2(HISTORY_DEPTH + 1);
    localparam int TW   = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int MD   = TYPE_COUNT * HISTORY_DEPTH;
    localparam int AW   = (MD > 1) ? $clog2(MD) : 1;
    localparam int SW   = TIME_W + HW + 1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [DRAW_W-1:0] DRAW_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [HW-1:0] LAST_SLOT = HW'(HISTORY_DEPTH - 1);
    localparam logic [TW-1:0] LAST_TYPE = TW'(TYPE_COUNT - 1);
    localparam logic [5:0] DIV_STEPS = 6'(SW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REC    = 4'd1;
    localparam logic [3:0] S_COMMIT = 4'd2;
    localparam logic [3:0] S_TYPE   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_LAST   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_WAIT   = 4'd8;
    localparam logic [3:0] S_RD     = 4'd9;

    logic [3:0] state_reg, state_next;

    // Per-type frame accumulators and ring bookkeeping.
    logic [TIME_W-1:0] acc_time_reg [TYPE_COUNT];
    logic [DRAW_W-1:0] acc_draw_reg [TYPE_COUNT];
    logic [TYPE_COUNT-1:0] seen_reg, present_reg;
    logic [HW-1:0] head_reg [TYPE_COUNT];
    logic [FW-1:0] fill_reg [TYPE_COUNT];
    logic [FNUM_W-1:0] last_fnum_reg;
    logic [CNT_W-1:0] frames_reg, overrun_reg;
    logic taken_reg;

    // History memory, one row per type.
    logic [TIME_W-1:0] hist_time_mem [MD];
    logic [DRAW_W-1:0] hist_draw_mem [MD];
    logic [TIME_W-1:0] rd_time_reg;
    logic [DRAW_W-1:0] rd_draw_reg;

    // Latched record and scan working registers.
    logic [TW-1:0] kind_reg;
    logic [19:0] ptime_reg;
    logic [15:0] pdraw_reg;
    logic [TW-1:0] t_reg;
    logic [HW-1:0] k_reg;
    logic rd_ok_reg;
    logic [SW-1:0] sum_reg, quo_reg;
    logic [FW:0] rem_reg;
    logic [5:0] div_cnt_reg;
    logic [TIME_W-1:0] pt_reg, lt_reg;
    logic [DRAW_W-1:0] pd_reg, ld_reg;

    logic out_valid_reg;

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Row base of the type in hand, and the read and write addresses.
    logic [AW-1:0] row_base;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [HW-1:0] newest_slot;
    assign row_base = AW'(HISTORY_DEPTH) * AW'(t_reg);
    assign newest_slot = (head_reg[t_reg] == '0) ? LAST_SLOT : head_reg[t_reg] - 1'b1;
    assign rd_addr = row_base + AW'((state_reg == S_LAST) ? newest_slot : k_reg);
    assign wr_addr = row_base + AW'(head_reg[t_reg]);

    logic [FW-1:0] cur_fill;
    assign cur_fill = fill_reg[t_reg];

    // Restoring divider step on the running remainder.
    logic [FW:0] rem_shift;
    logic rem_ge;
    assign rem_shift = {rem_reg[FW-1:0], sum_reg[SW-1]};
    assign rem_ge = rem_shift >= {1'b0, cur_fill};

    // Saturating record sums.
    logic [TIME_W:0] tsum;
    logic [DRAW_W:0] dsum;
    assign tsum = {1'b0, acc_time_reg[kind_reg]} + (TIME_W+1)'(ptime_reg);
    assign dsum = {1'b0, acc_draw_reg[kind_reg]} + (DRAW_W+1)'(pdraw_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_RECORD)
                        state_next = (32'(pass_kind) < TYPE_COUNT) ? S_REC : S_IDLE;
                    else
                        state_next = S_COMMIT;
                end
            end
            S_REC:    state_next = S_IDLE;
            S_COMMIT: state_next = (t_reg == LAST_TYPE) ? S_TYPE : S_COMMIT;
            S_TYPE:   state_next = (cur_fill == '0) ? S_EMIT : S_SCAN;
            S_SCAN:
                if (FW'(k_reg) + 1'b1 == cur_fill) state_next = S_LAST;
            S_LAST:   state_next = S_RD;
            S_RD:     state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == DIV_STEPS) state_next = S_EMIT;
            S_EMIT:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (out_acc)
                    state_next = (t_reg == LAST_TYPE) ? S_IDLE : S_TYPE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // History memory: at most one type written per commit cycle, registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_COMMIT && taken_reg && seen_reg[t_reg])
        begin
            hist_time_mem[wr_addr] <= acc_time_reg[t_reg];
            hist_draw_mem[wr_addr] <= acc_draw_reg[t_reg];
        end
        rd_time_reg <= hist_time_mem[rd_addr];
        rd_draw_reg <= hist_draw_mem[rd_addr];
    end

    // Main sequencer and state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int t = 0; t < TYPE_COUNT; t++)
            begin
                acc_time_reg[t] <= '0;
                acc_draw_reg[t] <= '0;
                head_reg[t] <= '0;
                fill_reg[t] <= '0;
            end
            seen_reg <= '0;
            present_reg <= '0;
            last_fnum_reg <= '0;
            frames_reg <= '0;
            overrun_reg <= '0;
            taken_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            t_reg <= '0;
            k_reg <= '0;
            rd_ok_reg <= 1'b0;
            div_cnt_reg <= '0;
            kind_reg <= '0;
            ptime_reg <= '0;
            pdraw_reg <= '0;
            sum_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            pt_reg <= '0;
            lt_reg <= '0;
            pd_reg <= '0;
            ld_reg <= '0;
            last_of_run <= 1'b0;
            type_index <= '0;
            sample_count <= '0;
            present_now <= 1'b0;
            latest_time <= '0;
            latest_draws <= '0;
            mean_time <= '0;
            max_time <= '0;
            max_draws <= '0;
            frame_taken <= 1'b0;
            overrun_total <= '0;
            frames_total <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_acc)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && req_type == REQ_RECORD)
                    begin
                        kind_reg <= TW'(pass_kind);
                        ptime_reg <= pass_time;
                        pdraw_reg <= pass_draws;
                    end
                    else if (in_acc)
                    begin
                        taken_reg <= (frame_number != '0) && (frame_number != last_fnum_reg);
                        t_reg <= '0;
                        if ((frame_number != '0) && (frame_number != last_fnum_reg))
                        begin
                            last_fnum_reg <= frame_number;
                            if (frames_reg != CNT_MAX)
                                frames_reg <= frames_reg + 1'b1;
                            if (budget_exceeded && overrun_reg != CNT_MAX)
                                overrun_reg <= overrun_reg + 1'b1;
                        end
                    end
                end
                S_REC:
                begin
                    acc_time_reg[kind_reg] <= tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
                    acc_draw_reg[kind_reg] <= dsum[DRAW_W] ? DRAW_MAX : dsum[DRAW_W-1:0];
                    seen_reg[kind_reg] <= 1'b1;
                end
                // One type per cycle: update its ring pointers and clear its accumulator.
                S_COMMIT:
                begin
                    if (taken_reg)
                    begin
                        present_reg[t_reg] <= seen_reg[t_reg];
                        if (seen_reg[t_reg])
                        begin
                            head_reg[t_reg] <= (head_reg[t_reg] == LAST_SLOT) ? '0
                                               : head_reg[t_reg] + 1'b1;
                            if (fill_reg[t_reg] != FW'(HISTORY_DEPTH))
                                fill_reg[t_reg] <= fill_reg[t_reg] + 1'b1;
                        end
                    end
                    acc_time_reg[t_reg] <= '0;
                    acc_draw_reg[t_reg] <= '0;
                    seen_reg[t_reg] <= 1'b0;
                    t_reg <= (t_reg == LAST_TYPE) ? '0 : t_reg + 1'b1;
                end
                S_TYPE:
                begin
                    k_reg <= '0;
                    rd_ok_reg <= 1'b0;
                    sum_reg <= '0;
                    pt_reg <= '0;
                    pd_reg <= '0;
                    lt_reg <= '0;
                    ld_reg <= '0;
                    quo_reg <= '0;
                end
                S_SCAN, S_LAST, S_RD:
                begin
                    if (state_reg == S_SCAN)
                        k_reg <= k_reg + 1'b1;
                    rd_ok_reg <= (state_reg == S_SCAN);
                    if (rd_ok_reg)
                    begin
                        sum_reg <= sum_reg + SW'(rd_time_reg);
                        if (rd_time_reg > pt_reg) pt_reg <= rd_time_reg;
                        if (rd_draw_reg > pd_reg) pd_reg <= rd_draw_reg;
                    end
                    if (state_reg == S_RD)
                    begin
                        lt_reg <= rd_time_reg;
                        ld_reg <= rd_draw_reg;
                        rem_reg <= '0;
                        div_cnt_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg != DIV_STEPS)
                    begin
                        rem_reg <= rem_ge ? rem_shift - {1'b0, cur_fill} : rem_shift;
                        sum_reg <= {sum_reg[SW-2:0], 1'b0};
                        quo_reg <= {quo_reg[SW-2:0], rem_ge};
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    last_of_run <= (t_reg == LAST_TYPE);
                    type_index <= 4'(t_reg);
                    sample_count <= 6'(cur_fill);
                    present_now <= present_reg[t_reg];
                    latest_time <= lt_reg;
                    latest_draws <= ld_reg;
                    mean_time <= quo_reg[TIME_W-1:0];
                    max_time <= pt_reg;
                    max_draws <= pd_reg;
                    frame_taken <= taken_reg;
                    overrun_total <= overrun_reg;
                    frames_total <= frames_reg;
                end
                S_WAIT:
                    if (out_acc && t_reg != LAST_TYPE)
                        t_reg <= t_reg + 1'b1;
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_out_only_waiting, clk, rst_n, out_valid_reg, state_reg == S_WAIT)
    `ASSERT_IMPL(a_no_input_busy, clk, rst_n, in_acc, state_reg == S_IDLE)
    `ASSERT_NEXT(a_close_starts, clk, rst_n, in_acc && req_type == REQ_CLOSE,
                 state_reg == S_COMMIT)
endmodule

### test/tb_top.sv
// Testbench for the pass cost window statistics block: directed and random requests.
// Depends on pcws_pkg and pass_cost_window_stats_top; predicts every attribution itself.
`timescale 1ns / 1ps
module tb_top;
    import pcws_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;
    localparam int KINDS = TYPE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [TIME_W-1:0] TIME_SAT = '1;
    localparam logic [DRAW_W-1:0] DRAW_SAT = '1;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef struct packed {
        logic              last_of_run;
        logic [3:0]        type_index;
        logic [5:0]        sample_count;
        logic              present_now;
        logic [TIME_W-1:0] latest_time;
        logic [DRAW_W-1:0] latest_draws;
        logic [TIME_W-1:0] mean_time;
        logic [TIME_W-1:0] max_time;
        logic [DRAW_W-1:0] max_draws;
        logic              frame_taken;
        logic [CNT_W-1:0]  overrun_total;
        logic [CNT_W-1:0]  frames_total;
    } attribution_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [3:0]  pass_kind;
    logic [19:0] pass_time;
    logic [15:0] pass_draws;
    logic [63:0] frame_number;
    logic        budget_exceeded;
    logic        out_valid;
    logic        out_stall;
    logic        last_of_run;
    logic [3:0]  type_index;
    logic [5:0]  sample_count;
    logic        present_now;
    logic [23:0] latest_time;
    logic [19:0] latest_draws;
    logic [23:0] mean_time;
    logic [23:0] max_time;
    logic [19:0] max_draws;
    logic        frame_taken;
    logic [31:0] overrun_total;
    logic [31:0] frames_total;

    // Predicted block state.
    logic [TIME_W-1:0] acc_time [KINDS];
    logic [DRAW_W-1:0] acc_draws [KINDS];
    logic              acc_seen [KINDS];
    logic [TIME_W-1:0] hist_time [KINDS][DEPTH];
    logic [DRAW_W-1:0] hist_draws [KINDS][DEPTH];
    int                ring_wr [KINDS];
    int                ring_count [KINDS];
    logic              in_last_frame [KINDS];
    logic [63:0]       last_frame_id;
    logic [CNT_W-1:0]  captured_count;
    logic [CNT_W-1:0]  overrun_count;

    attribution_t pending_attr [$];
    int           mismatches;
    int           cycles;
    int           burst_left;
    logic [63:0]  next_frame_id;

    pass_cost_window_stats_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .pass_kind       (pass_kind),
        .pass_time       (pass_time),
        .pass_draws      (pass_draws),
        .frame_number    (frame_number),
        .budget_exceeded (budget_exceeded),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .last_of_run     (last_of_run),
        .type_index      (type_index),
        .sample_count    (sample_count),
        .present_now     (present_now),
        .latest_time     (latest_time),
        .latest_draws    (latest_draws),
        .mean_time       (mean_time),
        .max_time        (max_time),
        .max_draws       (max_draws),
        .frame_taken     (frame_taken),
        .overrun_total   (overrun_total),
        .frames_total    (frames_total)
    );

    // Clock and cycle limit.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stall pattern: modes of none, light and heavy stalling chosen at random.
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", field, got, want, cycles);
    endtask

    // Checks each attribution taken by the receiver against the oldest prediction.
    initial
    begin
        attribution_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_attr.size() == 0)
                    report_mismatch("unexpected attribution", {60'd0, type_index}, 64'd0);
                else
                begin
                    want = pending_attr.pop_front();
                    if (last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 64'(last_of_run),
                                        64'(want.last_of_run));
                    if (type_index !== want.type_index)
                        report_mismatch("type_index", 64'(type_index),
                                        64'(want.type_index));
                    if (sample_count !== want.sample_count)
                        report_mismatch("sample_count", 64'(sample_count),
                                        64'(want.sample_count));
                    if (present_now !== want.present_now)
                        report_mismatch("present_now", 64'(present_now),
                                        64'(want.present_now));
                    if (latest_time !== want.latest_time)
                        report_mismatch("latest_time", 64'(latest_time),
                                        64'(want.latest_time));
                    if (latest_draws !== want.latest_draws)
                        report_mismatch("latest_draws", 64'(latest_draws),
                                        64'(want.latest_draws));
                    if (mean_time !== want.mean_time)
                        report_mismatch("mean_time", 64'(mean_time),
                                        64'(want.mean_time));
                    if (max_time !== want.max_time)
                        report_mismatch("max_time", 64'(max_time),
                                        64'(want.max_time));
                    if (max_draws !== want.max_draws)
                        report_mismatch("max_draws", 64'(max_draws),
                                        64'(want.max_draws));
                    if (frame_taken !== want.frame_taken)
                        report_mismatch("frame_taken", 64'(frame_taken),
                                        64'(want.frame_taken));
                    if (overrun_total !== want.overrun_total)
                        report_mismatch("overrun_total", 64'(overrun_total),
                                        64'(want.overrun_total));
                    if (frames_total !== want.frames_total)
                        report_mismatch("frames_total", 64'(frames_total),
                                        64'(want.frames_total));
                end
            end
        end
    end

    // Folds one accepted request into the predicted state and queues its attributions.
    task automatic predict_request(input logic rq, input logic [3:0] kind,
                                   input logic [19:0] ptime, input logic [15:0] pdraws,
                                   input logic [63:0] fid, input logic over);
        attribution_t a;
        logic [TIME_W:0] tsum;
        logic [DRAW_W:0] dsum;
        longint total;
        logic taken;
        int head;
        if (rq == REQ_RECORD)
        begin
            if (kind < KINDS)
            begin
                tsum = acc_time[kind] + ptime;
                dsum = acc_draws[kind] + pdraws;
                acc_time[kind] = tsum[TIME_W] ? TIME_SAT : tsum[TIME_W-1:0];
                acc_draws[kind] = dsum[DRAW_W] ? DRAW_SAT : dsum[DRAW_W-1:0];
                acc_seen[kind] = 1'b1;
            end
            return;
        end
        taken = (fid != 64'd0) && (fid != last_frame_id);
        if (taken)
        begin
            last_frame_id = fid;
            if (captured_count != CNT_SAT)
                captured_count++;
            if (over && overrun_count != CNT_SAT)
                overrun_count++;
            for (int k = 0; k < KINDS; k++)
            begin
                in_last_frame[k] = acc_seen[k];
                if (acc_seen[k])
                begin
                    hist_time[k][ring_wr[k]] = acc_time[k];
                    hist_draws[k][ring_wr[k]] = acc_draws[k];
                    ring_wr[k] = (ring_wr[k] + 1) % DEPTH;
                    if (ring_count[k] < DEPTH)
                        ring_count[k]++;
                end
            end
        end
        for (int k = 0; k < KINDS; k++)
        begin
            acc_time[k] = '0;
            acc_draws[k] = '0;
            acc_seen[k] = 1'b0;
        end
        for (int k = 0; k < KINDS; k++)
        begin
            a = '0;
            a.last_of_run = (k == KINDS - 1);
            a.type_index = 4'(k);
            a.sample_count = 6'(ring_count[k]);
            a.present_now = in_last_frame[k];
            a.frame_taken = taken;
            a.overrun_total = overrun_count;
            a.frames_total = captured_count;
            if (ring_count[k] > 0)
            begin
                head = (ring_wr[k] + DEPTH - 1) % DEPTH;
                a.latest_time = hist_time[k][head];
                a.latest_draws = hist_draws[k][head];
                total = 0;
                for (int s = 0; s < ring_count[k]; s++)
                begin
                    total += hist_time[k][s];
                    if (hist_time[k][s] > a.max_time)
                        a.max_time = hist_time[k][s];
                    if (hist_draws[k][s] > a.max_draws)
                        a.max_draws = hist_draws[k][s];
                end
                a.mean_time = TIME_W'(total / ring_count[k]);
            end
            pending_attr = {pending_attr, a};
        end
    endtask

    // Sends one request, with bursts of random length and, at random, gaps between them.
    task automatic send_request(input logic rq, input logic [3:0] kind,
                                input logic [19:0] ptime, input logic [15:0] pdraws,
                                input logic [63:0] fid, input logic over);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= rq;
        pass_kind <= kind;
        pass_time <= ptime;
        pass_draws <= pdraws;
        frame_number <= fid;
        budget_exceeded <= over;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        predict_request(rq, kind, ptime, pdraws, fid, over);
        @(posedge clk);
    endtask

    task automatic send_record(input logic [3:0] kind, input logic [19:0] ptime,
                               input logic [15:0] pdraws);
        send_request(REQ_RECORD, kind, ptime, pdraws, {$urandom, $urandom},
                     1'($urandom_range(0, 1)));
    endtask

    task automatic send_close(input logic [63:0] fid, input logic over);
        send_request(REQ_CLOSE, 4'($urandom_range(0, 15)), 20'($urandom_range(0, 1048575)),
                     16'($urandom_range(0, 65535)), fid, over);
    endtask

    // Directed: saturation, ignored types, zero and repeated frame ids, extremes.
    task automatic test_directed();
        repeat (17)
            send_record(4'd0, 20'hFFFFF, 16'hFFFF);
        send_record(4'd15, 20'hFFFFF, 16'hFFFF);
        send_record(4'(KINDS), 20'h12345, 16'h0042);
        send_record(4'(KINDS - 1), 20'h00000, 16'h0000);
        // A close with frame id zero commits nothing but still clears.
        send_close(64'd0, 1'b1);
        send_record(4'd2, 20'h00400, 16'h0007);
        send_close(64'd1, 1'b1);
        // Repeating the last frame id is refused.
        send_record(4'd1, 20'h00010, 16'h0003);
        send_close(64'd1, 1'b0);
        send_record(4'd3, 20'hFFFFF, 16'hFFFF);
        send_close(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    endtask

    // Many one-record frames on one type so that its ring wraps.
    task automatic test_ring_wrap();
        for (int f = 0; f < DEPTH + 6; f++)
        begin
            send_record(4'd0, 20'($urandom_range(0, 1048575)), 16'($urandom_range(0, 65535)));
            send_close(next_frame_id, 1'($urandom_range(0, 1)));
            next_frame_id++;
        end
    endtask

    // Random frames: mostly well-formed, with stray ids, zero ids and repeats.
    task automatic test_random_frames();
        int items;
        int choice;
        logic [63:0] fid;
        items = 0;
        while (items < 120)
        begin
            repeat ($urandom_range(0, 5))
            begin
                send_record(4'($urandom_range(0, 6) == 0 ? $urandom_range(0, 15)
                                                         : $urandom_range(0, KINDS - 1)),
                            20'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                                          : $urandom_range(0, 4096)),
                            16'($urandom_range(0, 65535)));
                items++;
            end
            choice = $urandom_range(0, 9);
            if (choice == 0)
                fid = 64'd0;
            else if (choice == 1)
                fid = last_frame_id;
            else if (choice == 2)
                fid = {$urandom, $urandom};
            else
            begin
                fid = next_frame_id;
                next_frame_id++;
            end
            send_close(fid, 1'($urandom_range(0, 1)));
            items++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_RECORD;
        pass_kind = '0;
        pass_time = '0;
        pass_draws = '0;
        frame_number = '0;
        budget_exceeded = 1'b0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        next_frame_id = 64'd2;
        last_frame_id = '0;
        captured_count = '0;
        overrun_count = '0;
        for (int k = 0; k < KINDS; k++)
        begin
            acc_time[k] = '0;
            acc_draws[k] = '0;
            acc_seen[k] = 1'b0;
            ring_wr[k] = 0;
            ring_count[k] = 0;
            in_last_frame[k] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_ring_wrap();
        test_random_frames();

        in_valid <= 1'b0;
        while (pending_attr.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
